FILE: src/fee_pkg.sv
package fee_pkg;

    // framing byte codes
    localparam logic [7:0] FLAG_BYTE = 8'h7e;
    localparam logic [7:0] ESC_BYTE  = 8'h7d;
    localparam logic [7:0] ESC_FLAG  = 8'h02;
    localparam logic [7:0] ESC_ESC   = 8'h01;
    localparam logic [7:0] ZERO_BYTE = 8'h00;

    // most output words one input word can cause
    localparam int unsigned MAX_OUT = 3;
    localparam int unsigned CNT_W   = $clog2(MAX_OUT + 1);
    localparam int unsigned IDX_W   = $clog2(MAX_OUT);

    // one byte after escaping: one or two wire bytes
    typedef struct packed {
        logic       two;
        logic [7:0] b0;
        logic [7:0] b1;
    } t_esc;

    // all output words caused by one input word
    typedef struct packed {
        logic [CNT_W-1:0]          cnt;
        logic [MAX_OUT-1:0][7:0]   bytes;
        logic                      closing;
    } t_bundle;

    // escape a body byte
    function automatic t_esc escape_byte(input logic [7:0] b);
        t_esc e;
        e.two = 1'b0;
        e.b0  = b;
        e.b1  = ZERO_BYTE;
        if (b == FLAG_BYTE) begin
            e.two = 1'b1;
            e.b0  = ESC_BYTE;
            e.b1  = ESC_FLAG;
        end else if (b == ESC_BYTE) begin
            e.two = 1'b1;
            e.b0  = ESC_BYTE;
            e.b1  = ESC_ESC;
        end
        return e;
    endfunction

endpackage

FILE: src/fee_core.sv
module fee_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [7:0] data_byte
    input  logic                  s_axis_tuser,   // [0] frame_open
    input  logic                  s_axis_tlast,   // frame_close
    input  logic                  i_out_free,
    output logic                  o_load,
    output fee_pkg::t_bundle      o_bundle
);

    logic             r_in_valid;
    logic [7:0]       r_in_data;
    logic             r_in_open;
    logic             r_in_close;
    logic [7:0]       r_held_byte;
    logic             r_held_valid;
    logic [7:0]       r_xor;
    logic             consume;
    fee_pkg::t_esc    esc_xor;
    fee_pkg::t_esc    esc_held;
    fee_pkg::t_bundle n_bundle;

    assign esc_xor  = fee_pkg::escape_byte(r_xor);
    assign esc_held = fee_pkg::escape_byte(r_held_byte);

    // build the output words for the registered input word
    always_comb begin
        n_bundle.cnt     = '0;
        n_bundle.bytes   = '0;
        n_bundle.closing = 1'b0;
        priority if (r_in_open) begin
            n_bundle.cnt      = fee_pkg::CNT_W'(1);
            n_bundle.bytes[0] = r_in_data;
        end else if (r_in_close) begin
            n_bundle.closing = 1'b1;
            if (r_held_valid) begin
                n_bundle.bytes[0] = esc_xor.b0;
                if (esc_xor.two) begin
                    n_bundle.bytes[1] = esc_xor.b1;
                    n_bundle.bytes[2] = r_in_data;
                    n_bundle.cnt      = fee_pkg::CNT_W'(3);
                end else begin
                    n_bundle.bytes[1] = r_in_data;
                    n_bundle.cnt      = fee_pkg::CNT_W'(2);
                end
            end else begin
                n_bundle.bytes[0] = r_in_data;
                n_bundle.cnt      = fee_pkg::CNT_W'(1);
            end
        end else begin
            // body word: release the held byte, if any
            if (r_held_valid) begin
                n_bundle.bytes[0] = esc_held.b0;
                n_bundle.bytes[1] = esc_held.b1;
                n_bundle.cnt      = esc_held.two ? fee_pkg::CNT_W'(2) : fee_pkg::CNT_W'(1);
            end
        end
    end

    // word leaves the input register when it has no results or its results have room
    assign consume       = r_in_valid && ((n_bundle.cnt == '0) || i_out_free);
    assign s_axis_tready = !r_in_valid || consume;
    assign o_load        = consume && (n_bundle.cnt != '0);
    assign o_bundle      = n_bundle;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_data  <= s_axis_tdata;
            r_in_open  <= s_axis_tuser;
            r_in_close <= s_axis_tlast;
        end
    end

    // held byte and running checksum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_byte  <= fee_pkg::ZERO_BYTE;
            r_held_valid <= 1'b0;
            r_xor        <= fee_pkg::ZERO_BYTE;
        end else if (consume) begin
            if (r_in_open || r_in_close) begin
                r_held_byte  <= fee_pkg::ZERO_BYTE;
                r_held_valid <= 1'b0;
                r_xor        <= fee_pkg::ZERO_BYTE;
            end else begin
                if (r_held_valid) begin
                    r_xor <= r_xor ^ r_held_byte;
                end
                r_held_byte  <= r_in_data;
                r_held_valid <= 1'b1;
            end
        end
    end

    // flag bytes end the held state and clear the checksum
    a_flag_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        consume && (r_in_open || r_in_close) |=> !r_held_valid && (r_xor == fee_pkg::ZERO_BYTE))
        else $error("flag word left a held byte or checksum");

    // a body word is always held afterwards
    a_body_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        consume && !r_in_open && !r_in_close |=> r_held_valid)
        else $error("body word not held");

    // a stalled input word keeps its contents
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !consume |=> r_in_valid && $stable(r_in_data)
            && $stable(r_in_open) && $stable(r_in_close))
        else $error("stalled input word changed");

endmodule

FILE: src/fee_out.sv
module fee_out (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  fee_pkg::t_bundle      i_bundle,
    output logic                  o_free,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [7:0]            m_axis_tdata,   // [7:0] out_byte
    output logic                  m_axis_tuser,   // [0] closing_flag
    output logic                  m_axis_tlast    // run_last
);

    logic                               r_valid;
    logic [fee_pkg::CNT_W-1:0]          r_cnt;
    logic [fee_pkg::IDX_W-1:0]          r_idx;
    logic [fee_pkg::MAX_OUT-1:0][7:0]   r_bytes;
    logic                               r_closing;
    logic                               last;

    // current word of the held result set
    assign last          = (fee_pkg::CNT_W'(r_idx) == r_cnt - fee_pkg::CNT_W'(1));
    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = r_bytes[r_idx];
    assign m_axis_tlast  = last;
    assign m_axis_tuser  = r_closing && last;
    assign o_free        = !r_valid || (m_axis_tready && last);

    // result set control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
        end else if (r_valid && m_axis_tready) begin
            if (last) begin
                r_valid <= 1'b0;
                r_idx   <= '0;
            end else begin
                r_idx <= r_idx + fee_pkg::IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_cnt     <= i_bundle.cnt;
            r_bytes   <= i_bundle.bytes;
            r_closing <= i_bundle.closing;
        end
    end

    // index stays inside the loaded set
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_cnt != '0) && (fee_pkg::CNT_W'(r_idx) < r_cnt))
        else $error("output index outside result set");

    // closing byte ends its run
    a_close_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tuser |-> m_axis_tlast)
        else $error("closing byte not last of run");

    // new set only overwrites a finished one
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> !r_valid || (m_axis_tready && last))
        else $error("result set overwritten");

endmodule

FILE: src/frame_escape_encoder.sv
// an accepted input word passes the input register, then the result register
// throughput: one output word per cycle while the receiver is ready; an input word is
//   taken each cycle while each causes at most one; escapes and checksums add words
// the output stage, one byte per cycle while the receiver is ready, sets the rate
// reset: synchronous active low; clears both stages, the held byte and the checksum
module frame_escape_encoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] frame_open
    input  logic        s_axis_tlast,   // frame_close
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic        m_axis_tuser,   // [0] closing_flag
    output logic        m_axis_tlast    // run_last
);

    logic             load;
    logic             out_free;
    fee_pkg::t_bundle bundle;

    // input register, checksum and escaping
    fee_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .i_out_free    (out_free),
        .o_load        (load),
        .o_bundle      (bundle)
    );

    // result register, one byte per word
    fee_out u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (load),
        .i_bundle      (bundle),
        .o_free        (out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

FILE: tb/sv/wire_byte_monitor.sv
module wire_byte_monitor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_in_data,
    input  logic        i_in_open,
    input  logic        i_in_close,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [7:0]  i_out_data,
    input  logic        i_out_closing,
    input  logic        i_out_last,
    output int          o_err_cnt,
    output int          o_pending,
    output int          o_words
);

    // one wire word as the encoder should send it
    typedef struct packed {
        logic [7:0] wire_byte;
        logic       run_last;
        logic       closing_flag;
    } t_wire_word;

    // predicted encoder state
    logic [7:0] hold_byte;
    logic       hold_vld;
    logic [7:0] frame_xor;

    // words caused by the current input word, before the last flag is set
    t_wire_word stage_w [fee_pkg::MAX_OUT];
    int         stage_n;

    t_wire_word wire_q [$];
    t_wire_word got_w;
    t_wire_word want_w;
    int         err_cnt;
    int         word_cnt;

    initial begin
        o_err_cnt = 0;
        o_pending = 0;
        o_words   = 0;
    end

    task automatic stage_word(input logic [7:0] b, input logic closing);
        stage_w[stage_n] = '{wire_byte: b, run_last: 1'b0, closing_flag: closing};
        stage_n++;
    endtask

    // body and checksum bytes go out escaped
    task automatic stage_escaped(input logic [7:0] b);
        if (b == fee_pkg::FLAG_BYTE) begin
            stage_word(fee_pkg::ESC_BYTE, 1'b0);
            stage_word(fee_pkg::ESC_FLAG, 1'b0);
        end else if (b == fee_pkg::ESC_BYTE) begin
            stage_word(fee_pkg::ESC_BYTE, 1'b0);
            stage_word(fee_pkg::ESC_ESC, 1'b0);
        end else begin
            stage_word(b, 1'b0);
        end
    endtask

    // work out the wire words caused by one accepted input word
    task automatic predict_wire_words(input logic [7:0] d, input logic op, input logic cl);
        stage_n = 0;
        if (op) begin
            frame_xor = '0;
            hold_vld  = 1'b0;
            hold_byte = '0;
            stage_word(d, 1'b0);
        end else if (cl) begin
            if (hold_vld) stage_escaped(frame_xor);
            stage_word(d, 1'b1);
            hold_vld  = 1'b0;
            hold_byte = '0;
            frame_xor = '0;
        end else begin
            if (hold_vld) begin
                frame_xor = frame_xor ^ hold_byte;
                stage_escaped(hold_byte);
            end
            hold_byte = d;
            hold_vld  = 1'b1;
        end
        for (int i = 0; i < stage_n; i++) begin
            if (i == stage_n - 1) stage_w[i].run_last = 1'b1;
            wire_q.insert(wire_q.size(), stage_w[i]);
        end
    endtask

    // compare output words first, then predict from the input word
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_byte = '0;
            hold_vld  = 1'b0;
            frame_xor = '0;
            wire_q.delete();
            err_cnt   = 0;
            word_cnt  = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                got_w = '{wire_byte: i_out_data, run_last: i_out_last,
                          closing_flag: i_out_closing};
                word_cnt++;
                if (wire_q.size() == 0) begin
                    err_cnt++;
                    $display("%0t: unexpected output word: byte %02h last %b closing %b",
                             $time, got_w.wire_byte, got_w.run_last, got_w.closing_flag);
                end else begin
                    want_w = wire_q.pop_front();
                    if (got_w.wire_byte !== want_w.wire_byte ||
                        got_w.run_last !== want_w.run_last ||
                        got_w.closing_flag !== want_w.closing_flag) begin
                        err_cnt++;
                        $display({"%0t: output word mismatch: ",
                                  "expected byte %02h last %b closing %b, ",
                                  "got byte %02h last %b closing %b"},
                                 $time, want_w.wire_byte, want_w.run_last,
                                 want_w.closing_flag, got_w.wire_byte, got_w.run_last,
                                 got_w.closing_flag);
                    end
                end
            end
            if (i_in_valid && i_in_ready) predict_wire_words(i_in_data, i_in_open, i_in_close);
        end
        o_err_cnt <= err_cnt;
        o_pending <= wire_q.size();
        o_words   <= word_cnt;
    end

endmodule

FILE: tb/sv/tb.sv
module tb;

    localparam int TOTAL_ITEMS = 470;
    localparam int HOLD_AT     = 150;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 2000;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = '0;      // [7:0] data_byte
    logic       s_axis_tuser = 1'b0;    // [0] frame_open
    logic       s_axis_tlast = 1'b0;    // frame_close
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;           // [7:0] out_byte
    logic       m_axis_tuser;           // [0] closing_flag
    logic       m_axis_tlast;           // run_last

    int  err_cnt;
    int  pending;
    int  words_out;
    int  items_sent = 0;
    int  frames_sent = 0;
    int  idle_cycles = 0;
    bit  send_burst = 1'b0;

    frame_escape_encoder uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    wire_byte_monitor mon (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (s_axis_tvalid),
        .i_in_ready    (s_axis_tready),
        .i_in_data     (s_axis_tdata),
        .i_in_open     (s_axis_tuser),
        .i_in_close    (s_axis_tlast),
        .i_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .i_out_data    (m_axis_tdata),
        .i_out_closing (m_axis_tuser),
        .i_out_last    (m_axis_tlast),
        .o_err_cnt     (err_cnt),
        .o_pending     (pending),
        .o_words       (words_out)
    );

    // clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("stalled for %0d cycles at %0t", idle_cycles, $time);
                $display("FAIL");
                $finish;
            end
        end
    end

    // offer one input word after a random gap, return at its accepting edge
    task automatic send_word(input logic [7:0] d, input logic op, input logic cl);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        s_axis_tuser  <= op;
        s_axis_tlast  <= cl;
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        items_sent++;
    endtask

    // flag bytes are mostly 0x7e, now and then anything
    function automatic logic [7:0] flag_value();
        return ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : fee_pkg::FLAG_BYTE;
    endfunction

    // body bytes lean toward the two bytes that need escaping
    function automatic logic [7:0] body_value();
        int pick;
        pick = $urandom_range(0, 7);
        if (pick == 0) return fee_pkg::FLAG_BYTE;
        if (pick == 1) return fee_pkg::ESC_BYTE;
        return 8'($urandom_range(0, 255));
    endfunction

    // receiver: random hold-offs, quiet stretches and one long stall
    initial begin : rx_proc
        int gap;
        int rx_words;
        rx_words = 0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (rx_words == HOLD_AT)
                gap = HOLD_CYCLES;
            else if ((rx_words / 50) % 3 == 1)
                gap = 0;
            else
                gap = $urandom_range(0, 7);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
            rx_words++;
        end
    end

    // stimulus and verdict
    initial begin : stim_proc
        int nbody;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // full frame with both escapes in the body
        send_word(fee_pkg::FLAG_BYTE, 1'b1, 1'b0);
        send_word(8'h00, 1'b0, 1'b0);
        send_word(8'hff, 1'b0, 1'b0);
        send_word(fee_pkg::FLAG_BYTE, 1'b0, 1'b0);
        send_word(fee_pkg::ESC_BYTE, 1'b0, 1'b0);
        send_word(8'h55, 1'b0, 1'b0);
        send_word(fee_pkg::FLAG_BYTE, 1'b0, 1'b1);
        frames_sent++;
        // checksum that needs the flag escape
        send_word(fee_pkg::FLAG_BYTE, 1'b1, 1'b0);
        send_word(fee_pkg::FLAG_BYTE, 1'b0, 1'b0);
        send_word(8'haa, 1'b0, 1'b0);
        send_word(fee_pkg::FLAG_BYTE, 1'b0, 1'b1);
        frames_sent++;
        // checksum that needs the escape-byte escape, odd flag values
        send_word(fee_pkg::ESC_BYTE, 1'b1, 1'b0);
        send_word(fee_pkg::ESC_BYTE, 1'b0, 1'b0);
        send_word(8'h11, 1'b0, 1'b0);
        send_word(8'h00, 1'b0, 1'b1);
        frames_sent++;
        // open and close on the same word
        send_word(8'hff, 1'b1, 1'b1);
        // frame with no body
        send_word(fee_pkg::FLAG_BYTE, 1'b1, 1'b0);
        send_word(fee_pkg::FLAG_BYTE, 1'b0, 1'b1);
        frames_sent++;
        // body words with no open, then an open drops the held byte
        send_word(8'h33, 1'b0, 1'b0);
        send_word(8'h44, 1'b0, 1'b0);
        send_word(fee_pkg::FLAG_BYTE, 1'b1, 1'b0);
        // single body word, zero checksum
        send_word(8'h66, 1'b0, 1'b0);
        send_word(8'hff, 1'b0, 1'b1);
        frames_sent++;

        // random frames with some noise and broken frames
        while (items_sent < TOTAL_ITEMS) begin
            send_burst = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 6) == 0) begin
                repeat ($urandom_range(1, 4))
                    send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)));
            end else begin
                send_word(flag_value(), 1'b1, 1'b0);
                nbody = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 24)
                                                    : $urandom_range(0, 6);
                repeat (nbody) send_word(body_value(), 1'b0, 1'b0);
                // now and then the close is missing and the next open cuts in
                if ($urandom_range(0, 9) != 0) send_word(flag_value(), 1'b0, 1'b1);
                frames_sent++;
            end
        end
        s_axis_tvalid <= 1'b0;

        // drain the encoder, then give it time to show stray words
        do @(posedge i_clk); while (pending != 0);
        repeat (8) @(posedge i_clk);

        $display("sent %0d input words in %0d frames, checked %0d output words",
                 items_sent, frames_sent, words_out);
        $display("mismatches and stray words: %0d", err_cnt);
        if (err_cnt == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
